/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the project.
// Self-contained; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/itp_pkg.sv */
// Package for the infix-to-postfix converter: sizes, character and stack codes,
// decode functions and the controller/datapath interface structs. No dependencies.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_LP    = 8'h28;
    localparam logic [7:0] CH_RP    = 8'h29;

    localparam logic [2:0] CODE_LP    = 3'd0;
    localparam logic [2:0] CODE_PLUS  = 3'd1;
    localparam logic [2:0] CODE_MINUS = 3'd2;
    localparam logic [2:0] CODE_MUL   = 3'd3;
    localparam logic [2:0] CODE_DIV   = 3'd4;
    localparam logic [2:0] CODE_POW   = 3'd5;

    localparam logic [1:0] CLS_OPERAND = 2'd0;
    localparam logic [1:0] CLS_LP      = 2'd1;
    localparam logic [1:0] CLS_RP      = 2'd2;
    localparam logic [1:0] CLS_OP      = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic emit_in;
        logic emit_top;
        logic set_overflow;
        logic set_unmatched;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] cls;
        logic       last;
        logic       empty;
        logic       full;
        logic       top_lp;
        logic       top_oper;
        logic       top_pops;
        logic       pend_valid;
        logic       slot_free;
        logic       err_any;
    } t_stat;

    function automatic logic [1:0] f_class(input logic [7:0] ch);
        case (ch)
            CH_LP:                                    f_class = CLS_LP;
            CH_RP:                                    f_class = CLS_RP;
            CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW: f_class = CLS_OP;
            default:                                  f_class = CLS_OPERAND;
        endcase
    endfunction

    function automatic logic [2:0] f_op_code(input logic [7:0] ch);
        case (ch)
            CH_PLUS:  f_op_code = CODE_PLUS;
            CH_MINUS: f_op_code = CODE_MINUS;
            CH_MUL:   f_op_code = CODE_MUL;
            CH_DIV:   f_op_code = CODE_DIV;
            CH_POW:   f_op_code = CODE_POW;
            default:  f_op_code = CODE_LP;
        endcase
    endfunction

    function automatic logic [7:0] f_code_char(input logic [2:0] code);
        case (code)
            CODE_LP:    f_code_char = CH_LP;
            CODE_PLUS:  f_code_char = CH_PLUS;
            CODE_MINUS: f_code_char = CH_MINUS;
            CODE_MUL:   f_code_char = CH_MUL;
            CODE_DIV:   f_code_char = CH_DIV;
            CODE_POW:   f_code_char = CH_POW;
            default:    f_code_char = 8'h00;
        endcase
    endfunction

    function automatic logic [1:0] f_prec(input logic [2:0] code);
        case (code)
            CODE_PLUS, CODE_MINUS: f_prec = 2'd1;
            CODE_MUL, CODE_DIV:    f_prec = 2'd2;
            CODE_POW:              f_prec = 2'd3;
            default:               f_prec = 2'd0;
        endcase
    endfunction

    function automatic logic f_is_oper(input logic [2:0] code);
        f_is_oper = (code != CODE_LP) && (code <= CODE_POW);
    endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter_top.sv */
// Infix-to-postfix converter top level (operator stack, shunting-yard order).
// Each character is registered, then handled in a work state; a last character
// also flushes the stack. A new character is taken only in the idle or final state.
// The single-port operator stack pops one entry per cycle unless the output stalls.
// Reset (synchronous, active low) empties the stack and drops any pending result.
// Depends on itp_pkg, itp_ctrl and itp_dpath.
module infix_to_postfix_converter_top
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [3:0] m_axis_tuser,   // [0] char_valid, [1] expr_end, [3:2] error
    output logic       m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;
    logic  char_valid;
    logic  expr_end;
    logic [1:0] error_code;

    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    itp_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_char    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_char   (m_axis_tdata),
        .o_char_valid (char_valid),
        .o_run_last   (m_axis_tlast),
        .o_expr_end   (expr_end),
        .o_error      (error_code)
    );

    assign m_axis_tuser = {error_code, expr_end, char_valid};

endmodule

/* hw/rtl/itp_ctrl.sv */
// Controller state machine of the infix-to-postfix converter.
// Depends on itp_pkg; drives the command struct of itp_dpath from its status struct.
module itp_ctrl
    import itp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WORK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       stall;
    logic       need;
    logic [1:0] after_work;

    assign stall      = i_stat.pend_valid && !i_stat.slot_free;
    assign need       = i_stat.pend_valid || i_stat.last || i_stat.err_any;
    assign after_work = i_stat.last ? S_FLUSH : S_FINAL;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WORK;
                end
            end
            S_WORK: begin
                case (i_stat.cls)
                    CLS_OPERAND: begin
                        o_cmd.emit_in = 1'b1;
                        n_state       = after_work;
                    end
                    CLS_LP: begin
                        if (i_stat.full) begin
                            o_cmd.set_overflow = 1'b1;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                        n_state = after_work;
                    end
                    CLS_RP: begin
                        if (!i_stat.empty && !i_stat.top_lp) begin
                            if (!stall) begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.emit_top = 1'b1;
                            end
                        end else if (!i_stat.empty) begin
                            o_cmd.pop = 1'b1;
                            n_state   = after_work;
                        end else begin
                            o_cmd.set_unmatched = 1'b1;
                            n_state             = after_work;
                        end
                    end
                    default: begin
                        if (!i_stat.empty && i_stat.top_pops) begin
                            if (!stall) begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.emit_top = 1'b1;
                            end
                        end else begin
                            if (i_stat.full) begin
                                o_cmd.set_overflow = 1'b1;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                            n_state = after_work;
                        end
                    end
                endcase
            end
            S_FLUSH: begin
                if (i_stat.empty) begin
                    n_state = S_FINAL;
                end else if (i_stat.top_oper) begin
                    if (!stall) begin
                        o_cmd.pop      = 1'b1;
                        o_cmd.emit_top = 1'b1;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            S_FINAL: begin
                if (!need || i_stat.slot_free) begin
                    o_cmd.finish = need;
                    o_ready      = 1'b1;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_WORK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/itp_dpath.sv */
// Datapath of the infix-to-postfix converter: item registers, operator stack,
// one-deep pending result and the output register. Depends on itp_pkg.
module itp_dpath
    import itp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic       o_run_last,
    output logic       o_expr_end,
    output logic [1:0] o_error
);

    logic [7:0]       r_char;
    logic             r_last;
    logic [1:0]       r_cls;
    logic [2:0]       r_op;
    logic [2:0]       r_stack [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic             r_pend_valid;
    logic [7:0]       r_pend_char;
    logic [1:0]       r_err;
    logic             r_ovalid;
    logic [7:0]       r_ochar;
    logic             r_ocv;
    logic             r_olast;
    logic             r_oend;
    logic [1:0]       r_oerr;

    logic [PTR_W-1:0] top_idx;
    logic [2:0]       top;
    logic [7:0]       emit_char;
    logic             emit;
    logic             slot_free;

    assign top_idx   = PTR_W'(r_count - CNT_W'(1));
    assign top       = r_stack[top_idx];
    assign emit      = i_cmd.emit_in || i_cmd.emit_top;
    assign emit_char = i_cmd.emit_in ? r_char : f_code_char(top);
    assign slot_free = !r_ovalid || i_out_ready;

    always_comb begin
        o_stat.cls        = r_cls;
        o_stat.last       = r_last;
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count >= CNT_W'(STACK_DEPTH));
        o_stat.top_lp     = (top == CODE_LP);
        o_stat.top_oper   = f_is_oper(top);
        o_stat.top_pops   = f_is_oper(top) && (f_prec(top) >= f_prec(r_op));
        o_stat.pend_valid = r_pend_valid;
        o_stat.slot_free  = slot_free;
        o_stat.err_any    = (r_err != ERR_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_in_char;
            r_last <= i_in_last;
            r_cls  <= f_class(i_in_char);
            r_op   <= f_op_code(i_in_char);
        end
        if (i_cmd.push) begin
            r_stack[r_count[PTR_W-1:0]] <= (r_cls == CLS_LP) ? CODE_LP : r_op;
        end
        if (emit) begin
            r_pend_char <= emit_char;
        end
        if (emit && r_pend_valid) begin
            r_ochar <= r_pend_char;
            r_ocv   <= 1'b1;
            r_olast <= 1'b0;
            r_oend  <= 1'b0;
            r_oerr  <= ERR_NONE;
        end else if (i_cmd.finish) begin
            r_ochar <= r_pend_valid ? r_pend_char : 8'h00;
            r_ocv   <= r_pend_valid;
            r_olast <= 1'b1;
            r_oend  <= r_last;
            r_oerr  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_err        <= ERR_NONE;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.set_overflow) begin
                r_err <= ERR_OVERFLOW;
            end else if (i_cmd.set_unmatched) begin
                r_err <= ERR_UNMATCHED;
            end else if (i_cmd.load) begin
                r_err <= ERR_NONE;
            end
            if ((emit && r_pend_valid) || i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_char   = r_ochar;
    assign o_char_valid = r_ocv;
    assign o_run_last   = r_olast;
    assign o_expr_end   = r_oend;
    assign o_error      = r_oerr;

endmodule

/* hw/rtl/itp_checker.sv */
// Port-level checker for the infix-to-postfix converter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module itp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    `AST_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled output item changed")
    `AST_SAME(a_marker_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == 8'h00), "Marker item not last of its run or not zero")
    `AST_SAME(a_err_on_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[3:2] != 2'd0), m_axis_tlast, "Error flagged on an item that is not last of its run")
    `AST_SAME(a_end_on_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "Expression end on an item that is not last of its run")
    `AST_SAME(a_err_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[3:2] != 2'd3, "Unknown error code")

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (.*);

/* tb/infix_to_postfix_converter_top_test.sv */
// Self-checking testbench for infix_to_postfix_converter_top: drives expression characters
// on the input stream and checks every postfix item against a built-in operator-stack predictor.
// Depends on itp_pkg and the converter RTL.
module infix_to_postfix_converter_top_test
    import itp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;

    typedef struct packed {
        logic [7:0] ch;
        logic       char_valid;
        logic       run_last;
        logic       expr_end;
        logic [1:0] err;
    } t_postfix_item;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_char
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_char
    logic [3:0] m_axis_tuser;   // [0] char_valid, [1] expr_end, [3:2] error
    logic       m_axis_tlast;

    t_postfix_item postfix_q[$];
    logic [7:0]    expr_chars[$];
    logic [2:0]    op_stack[STACK_DEPTH];
    int            stack_cnt;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_left;
    int            mismatch_cnt;
    int            quiet_cycles;

    infix_to_postfix_converter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic bit is_operator(input logic [7:0] ch);
        return ch == CH_PLUS || ch == CH_MINUS || ch == CH_MUL || ch == CH_DIV ||
               ch == CH_POW;
    endfunction

    function automatic bit is_special(input logic [7:0] ch);
        return is_operator(ch) || ch == CH_LP || ch == CH_RP;
    endfunction

    function automatic logic [2:0] stack_code(input logic [7:0] ch);
        case (ch)
            CH_PLUS:  return CODE_PLUS;
            CH_MINUS: return CODE_MINUS;
            CH_MUL:   return CODE_MUL;
            CH_DIV:   return CODE_DIV;
            CH_POW:   return CODE_POW;
            default:  return CODE_LP;
        endcase
    endfunction

    function automatic logic [7:0] code_to_char(input logic [2:0] code);
        case (code)
            CODE_PLUS:  return CH_PLUS;
            CODE_MINUS: return CH_MINUS;
            CODE_MUL:   return CH_MUL;
            CODE_DIV:   return CH_DIV;
            CODE_POW:   return CH_POW;
            default:    return CH_LP;
        endcase
    endfunction

    function automatic int binding_of(input logic [2:0] code);
        case (code)
            CODE_PLUS, CODE_MINUS: return 1;
            CODE_MUL, CODE_DIV:    return 2;
            CODE_POW:              return 3;
            default:               return 0;
        endcase
    endfunction

    function automatic void emit_postfix(input logic [7:0] ch, input logic valid);
        t_postfix_item it;
        it = '{ch: ch, char_valid: valid, run_last: 1'b0, expr_end: 1'b0, err: ERR_NONE};
        postfix_q.push_back(it);
    endfunction

    // Advances the operator stack by one character and queues the postfix items it releases.
    function automatic void convert_char(input logic [7:0] ch, input logic is_last);
        int         start_size;
        logic [1:0] err;
        logic [2:0] code;
        start_size = postfix_q.size();
        err = ERR_NONE;
        if (ch == CH_LP) begin
            if (stack_cnt < STACK_DEPTH) begin
                op_stack[stack_cnt] = CODE_LP;
                stack_cnt++;
            end else begin
                err = ERR_OVERFLOW;
            end
        end else if (ch == CH_RP) begin
            while (stack_cnt > 0 && op_stack[stack_cnt - 1] != CODE_LP) begin
                stack_cnt--;
                emit_postfix(code_to_char(op_stack[stack_cnt]), 1'b1);
            end
            if (stack_cnt > 0) stack_cnt--;
            else err = ERR_UNMATCHED;
        end else if (is_operator(ch)) begin
            code = stack_code(ch);
            while (stack_cnt > 0 && op_stack[stack_cnt - 1] != CODE_LP &&
                   binding_of(op_stack[stack_cnt - 1]) >= binding_of(code)) begin
                stack_cnt--;
                emit_postfix(code_to_char(op_stack[stack_cnt]), 1'b1);
            end
            if (stack_cnt < STACK_DEPTH) begin
                op_stack[stack_cnt] = code;
                stack_cnt++;
            end else begin
                err = ERR_OVERFLOW;
            end
        end else begin
            emit_postfix(ch, 1'b1);
        end
        if (is_last) begin
            while (stack_cnt > 0) begin
                stack_cnt--;
                if (op_stack[stack_cnt] != CODE_LP)
                    emit_postfix(code_to_char(op_stack[stack_cnt]), 1'b1);
            end
        end
        if (postfix_q.size() == start_size && (is_last || err != ERR_NONE))
            emit_postfix(8'h00, 1'b0);
        if (postfix_q.size() > start_size) begin
            postfix_q[postfix_q.size() - 1].run_last = 1'b1;
            postfix_q[postfix_q.size() - 1].expr_end = is_last;
            postfix_q[postfix_q.size() - 1].err      = err;
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = ch;
        s_axis_tlast  = is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        convert_char(ch, is_last);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_text(input string s, input logic end_expr);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_expr && (i == s.len() - 1));
    endtask

    task automatic send_expr_chars();
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        expr_chars.delete();
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255)); while (is_special(ch));
        return ch;
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    task automatic build_term(input int depth);
        if (depth > 0 && $urandom_range(0, 3) == 0) begin
            expr_chars.push_back(CH_LP);
            build_sum(depth - 1);
            if ($urandom_range(0, 9) != 0) expr_chars.push_back(CH_RP);
        end else begin
            expr_chars.push_back(random_operand());
        end
    endtask

    task automatic build_sum(input int depth);
        int terms;
        terms = $urandom_range(0, 4);
        build_term(depth);
        repeat (terms) begin
            expr_chars.push_back(random_operator());
            build_term(depth);
        end
    endtask

    function automatic void build_noise();
        int len;
        len = $urandom_range(1, 12);
        repeat (len) begin
            case ($urandom_range(0, 3))
                0:       expr_chars.push_back(random_operand());
                1:       expr_chars.push_back(CH_LP);
                2:       expr_chars.push_back(CH_RP);
                default: expr_chars.push_back(random_operator());
            endcase
        end
    endfunction

    task automatic wait_drained();
        while (postfix_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_char(8'h00, 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("*c^d^e-f", 1'b1);
        send_text("a+b)", 1'b0);
        send_text("c", 1'b1);
        send_text("((a/b", 1'b1);
        send_text("(", 1'b1);
        send_text(")", 1'b1);
        wait_drained();
    endtask

    task automatic test_stack_overflow();
        for (int i = 0; i < STACK_DEPTH / 2 + 2; i++) send_text("a+(", 1'b0);
        send_text("b)", 1'b1);
        repeat (STACK_DEPTH + 3) send_char(CH_LP, 1'b0);
        send_text(")x", 1'b1);
        wait_drained();
    endtask

    task automatic test_random_expressions(input int items);
        int sent;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 99) < 85) build_sum(3);
            else build_noise();
            sent += expr_chars.size();
            send_expr_chars();
        end
        wait_drained();
    endtask

    // The output is held not ready, so the input stalls behind it; then a full stack is flushed.
    task automatic test_output_stall();
        hold_left = 400;
        for (int i = 0; i < STACK_DEPTH / 2; i++) begin
            send_char(random_operand(), 1'b0);
            send_char(random_operator(), 1'b0);
            send_char(CH_LP, 1'b0);
        end
        send_char(random_operand(), 1'b1);
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_postfix_item got;
        t_postfix_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{ch: m_axis_tdata, char_valid: m_axis_tuser[0], run_last: m_axis_tlast,
                    expr_end: m_axis_tuser[1], err: m_axis_tuser[3:2]};
            if (postfix_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("Unexpected item: char %h valid %b last %b end %b error %0d",
                             got.ch, got.char_valid, got.run_last, got.expr_end, got.err);
            end else begin
                want = postfix_q.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $write("Mismatch: expected char %h valid %b last %b end %b error %0d,",
                               want.ch, want.char_valid, want.run_last, want.expr_end,
                               want.err);
                        $display(" got char %h valid %b last %b end %b error %0d",
                                 got.ch, got.char_valid, got.run_last, got.expr_end,
                                 got.err);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        stack_cnt     = 0;
        hold_left     = 0;
        mismatch_cnt  = 0;
        quiet_cycles  = 0;
        send_idle_pct = 26;
        recv_idle_pct = 56;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_stack_overflow();
        test_random_expressions(60);
        send_idle_pct = 56;
        recv_idle_pct = 26;
        test_random_expressions(60);
        test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_expressions(60);

        if (mismatch_cnt == 0 && postfix_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
